>>> sv/sm83pd_pkg.sv
// Shared types and codes for the SM83 instruction predecoder.
// The decode stage and the top level both use this package. It has no dependencies.
package sm83pd_pkg;

    // Mnemonic codes, numbered in decode order
    localparam logic [5:0] MN_LD   = 6'd0;
    localparam logic [5:0] MN_DAA  = 6'd1;
    localparam logic [5:0] MN_CPL  = 6'd2;
    localparam logic [5:0] MN_ADD  = 6'd3;
    localparam logic [5:0] MN_RLCA = 6'd4;
    localparam logic [5:0] MN_RLA  = 6'd5;
    localparam logic [5:0] MN_RRCA = 6'd6;
    localparam logic [5:0] MN_RRA  = 6'd7;
    localparam logic [5:0] MN_CCF  = 6'd8;
    localparam logic [5:0] MN_SCF  = 6'd9;
    localparam logic [5:0] MN_NOP  = 6'd10;
    localparam logic [5:0] MN_HALT = 6'd11;
    localparam logic [5:0] MN_STOP = 6'd12;
    localparam logic [5:0] MN_DI   = 6'd13;
    localparam logic [5:0] MN_EI   = 6'd14;
    localparam logic [5:0] MN_JP   = 6'd15;
    localparam logic [5:0] MN_JR   = 6'd16;
    localparam logic [5:0] MN_CALL = 6'd17;
    localparam logic [5:0] MN_RET  = 6'd18;
    localparam logic [5:0] MN_RETI = 6'd19;
    localparam logic [5:0] MN_ADC  = 6'd20;
    localparam logic [5:0] MN_INC  = 6'd27;
    localparam logic [5:0] MN_DEC  = 6'd28;
    localparam logic [5:0] MN_POP  = 6'd29;
    localparam logic [5:0] MN_PUSH = 6'd30;
    localparam logic [5:0] MN_RST  = 6'd31;
    localparam logic [5:0] MN_RLC  = 6'd32;
    localparam logic [5:0] MN_BIT  = 6'd40;

    // 8-bit register codes
    localparam logic [2:0] REG_C      = 3'd1;
    localparam logic [2:0] REG_HL_MEM = 3'd6;
    localparam logic [2:0] REG_A      = 3'd7;

    // Register pair codes
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    typedef struct packed {
        logic        recognized;
        logic [1:0]  inst_length;
        logic [2:0]  machine_cycles;
        logic [5:0]  mnemonic;
        logic [2:0]  dst_reg;
        logic [2:0]  src_reg;
        logic [1:0]  pair_sel;
        logic        has_condition;
        logic [1:0]  condition;
        logic [2:0]  bit_number;
        logic [15:0] operand_value;
    } dec_result_t;

    // ALU group: add, adc, sub, sbc, and, xor, or, cp
    function automatic logic [5:0] alu_mnemonic(input logic [2:0] sel);
        logic [5:0] mn;
        if (sel == 3'd0) begin
            mn = MN_ADD;
        end else begin
            mn = MN_ADC + {3'd0, sel} - 6'd1;
        end
        return mn;
    endfunction

endpackage

>>> sv/sm83pd_decode.sv
// Combinational decode of one SM83 instruction window, primary and CB pages.
// Depends on sm83pd_pkg for the result struct and the mnemonic and register codes.
module sm83pd_decode
    import sm83pd_pkg::*;
(
    input  logic [15:0]  instruction_address,
    input  logic [7:0]   opcode_byte,
    input  logic [7:0]   next_byte,
    input  logic [7:0]   third_byte,
    output dec_result_t  result
);

    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_LD_BC_A   = 8'h02;
    localparam logic [7:0] OP_RLCA      = 8'h07;
    localparam logic [7:0] OP_LD_NN_SP  = 8'h08;
    localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
    localparam logic [7:0] OP_RRCA      = 8'h0F;
    localparam logic [7:0] OP_STOP      = 8'h10;
    localparam logic [7:0] OP_LD_DE_A   = 8'h12;
    localparam logic [7:0] OP_RLA       = 8'h17;
    localparam logic [7:0] OP_JR        = 8'h18;
    localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
    localparam logic [7:0] OP_RRA       = 8'h1F;
    localparam logic [7:0] OP_LD_HLI_A  = 8'h22;
    localparam logic [7:0] OP_DAA       = 8'h27;
    localparam logic [7:0] OP_LD_A_HLI  = 8'h2A;
    localparam logic [7:0] OP_CPL       = 8'h2F;
    localparam logic [7:0] OP_LD_HLD_A  = 8'h32;
    localparam logic [7:0] OP_SCF       = 8'h37;
    localparam logic [7:0] OP_LD_A_HLD  = 8'h3A;
    localparam logic [7:0] OP_CCF       = 8'h3F;
    localparam logic [7:0] OP_HALT      = 8'h76;
    localparam logic [7:0] OP_JP        = 8'hC3;
    localparam logic [7:0] OP_RET       = 8'hC9;
    localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
    localparam logic [7:0] OP_CALL      = 8'hCD;
    localparam logic [7:0] OP_RETI      = 8'hD9;
    localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
    localparam logic [7:0] OP_LD_C_A    = 8'hE2;
    localparam logic [7:0] OP_ADD_SP_E  = 8'hE8;
    localparam logic [7:0] OP_JP_HL     = 8'hE9;
    localparam logic [7:0] OP_LD_NN_A   = 8'hEA;
    localparam logic [7:0] OP_LDH_A_N   = 8'hF0;
    localparam logic [7:0] OP_LD_A_C    = 8'hF2;
    localparam logic [7:0] OP_DI        = 8'hF3;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
    localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
    localparam logic [7:0] OP_LD_A_NN   = 8'hFA;
    localparam logic [7:0] OP_EI        = 8'hFB;

    logic [1:0]  op_hi;
    logic [2:0]  op_mid;
    logic [2:0]  op_lo;
    logic [1:0]  cb_hi;
    logic [2:0]  cb_mid;
    logic [2:0]  cb_lo;
    logic [15:0] imm16;
    logic [15:0] sext;
    logic [15:0] target;

    assign op_hi  = opcode_byte[7:6];
    assign op_mid = opcode_byte[5:3];
    assign op_lo  = opcode_byte[2:0];
    assign cb_hi  = next_byte[7:6];
    assign cb_mid = next_byte[5:3];
    assign cb_lo  = next_byte[2:0];
    assign imm16  = {third_byte, next_byte};
    assign sext   = {{8{next_byte[7]}}, next_byte};
    assign target = instruction_address + 16'd2 + sext;

    always_comb begin
        result = '0;
        case (opcode_byte)
            OP_LD_A_BC, OP_LD_A_DE: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, REG_A, 3'd0,
                           {1'b0, opcode_byte[4]}, 1'b0, 2'd0, 3'd0, 16'd0};
            end
            OP_LD_BC_A, OP_LD_DE_A: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, 3'd0, REG_A,
                           {1'b0, opcode_byte[4]}, 1'b0, 2'd0, 3'd0, 16'd0};
            end
            OP_LD_A_NN: begin
                result = '{1'b1, 2'd3, 3'd4, MN_LD, REG_A, 3'd0, 2'd0, 1'b0, 2'd0,
                           3'd0, imm16};
            end
            OP_LD_NN_A: begin
                result = '{1'b1, 2'd3, 3'd4, MN_LD, 3'd0, REG_A, 2'd0, 1'b0, 2'd0,
                           3'd0, imm16};
            end
            OP_LDH_A_N: begin
                result = '{1'b1, 2'd2, 3'd3, MN_LD, REG_A, 3'd0, 2'd0, 1'b0, 2'd0,
                           3'd0, {8'd0, next_byte}};
            end
            OP_LDH_N_A: begin
                result = '{1'b1, 2'd2, 3'd3, MN_LD, 3'd0, REG_A, 2'd0, 1'b0, 2'd0,
                           3'd0, {8'd0, next_byte}};
            end
            OP_LD_NN_SP: begin
                result = '{1'b1, 2'd3, 3'd5, MN_LD, 3'd0, 3'd0, PAIR_SP, 1'b0, 2'd0,
                           3'd0, imm16};
            end
            OP_LD_A_C: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, REG_A, REG_C, 2'd0, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_LD_C_A: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, REG_C, REG_A, 2'd0, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_LD_HLI_A, OP_LD_HLD_A: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, 3'd0, REG_A, PAIR_HL, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_LD_A_HLI, OP_LD_A_HLD: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, REG_A, 3'd0, PAIR_HL, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_LD_SP_HL: begin
                result = '{1'b1, 2'd1, 3'd2, MN_LD, 3'd0, 3'd0, PAIR_SP, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_DAA: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd1; result.mnemonic = MN_DAA;
                result.dst_reg = REG_A;
            end
            OP_CPL: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd1; result.mnemonic = MN_CPL;
                result.dst_reg = REG_A;
            end
            OP_ADD_SP_E: begin
                result = '{1'b1, 2'd2, 3'd4, MN_ADD, 3'd0, 3'd0, PAIR_SP, 1'b0, 2'd0,
                           3'd0, sext};
            end
            OP_LD_HL_SPE: begin
                result = '{1'b1, 2'd2, 3'd3, MN_LD, 3'd0, 3'd0, PAIR_HL, 1'b0, 2'd0,
                           3'd0, sext};
            end
            OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd1; result.dst_reg = REG_A;
                case (opcode_byte)
                    OP_RLCA: result.mnemonic = MN_RLCA;
                    OP_RLA:  result.mnemonic = MN_RLA;
                    OP_RRCA: result.mnemonic = MN_RRCA;
                    default: result.mnemonic = MN_RRA;
                endcase
            end
            OP_CCF, OP_SCF, OP_NOP, OP_HALT, OP_DI, OP_EI: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd1;
                case (opcode_byte)
                    OP_CCF:  result.mnemonic = MN_CCF;
                    OP_SCF:  result.mnemonic = MN_SCF;
                    OP_NOP:  result.mnemonic = MN_NOP;
                    OP_HALT: result.mnemonic = MN_HALT;
                    OP_DI:   result.mnemonic = MN_DI;
                    default: result.mnemonic = MN_EI;
                endcase
            end
            OP_STOP: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.mnemonic = MN_STOP;
            end
            OP_JP: begin
                result = '{1'b1, 2'd3, 3'd4, MN_JP, 3'd0, 3'd0, 2'd0, 1'b0, 2'd0,
                           3'd0, imm16};
            end
            OP_JP_HL: begin
                result = '{1'b1, 2'd1, 3'd1, MN_JP, 3'd0, 3'd0, PAIR_HL, 1'b0, 2'd0,
                           3'd0, 16'd0};
            end
            OP_JR: begin
                result = '{1'b1, 2'd2, 3'd3, MN_JR, 3'd0, 3'd0, 2'd0, 1'b0, 2'd0,
                           3'd0, target};
            end
            OP_CALL: begin
                result = '{1'b1, 2'd3, 3'd6, MN_CALL, 3'd0, 3'd0, 2'd0, 1'b0, 2'd0,
                           3'd0, imm16};
            end
            OP_RET: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd4; result.mnemonic = MN_RET;
            end
            OP_RETI: begin
                result.recognized = 1'b1; result.inst_length = 2'd1;
                result.machine_cycles = 3'd4; result.mnemonic = MN_RETI;
            end
            OP_PREFIX_CB: begin
                result.recognized = 1'b1;
                result.inst_length = 2'd2;
                result.dst_reg = cb_lo;
                if (cb_hi == 2'd0) begin
                    // rotates and shifts
                    result.mnemonic = MN_RLC + {3'd0, cb_mid};
                    result.machine_cycles = (cb_lo == REG_HL_MEM) ? 3'd4 : 3'd2;
                end else begin
                    // bit, res, set
                    result.bit_number = cb_mid;
                    result.mnemonic = MN_BIT + {4'd0, cb_hi} - 6'd1;
                    if (cb_lo != REG_HL_MEM) begin
                        result.machine_cycles = 3'd2;
                    end else if (cb_hi == 2'd1) begin
                        result.machine_cycles = 3'd3;
                    end else begin
                        result.machine_cycles = 3'd4;
                    end
                end
            end
            default: begin
                case (op_hi)
                    2'd1: begin
                        result.recognized = 1'b1; result.inst_length = 2'd1;
                        result.mnemonic = MN_LD;
                        result.dst_reg = op_mid; result.src_reg = op_lo;
                        result.machine_cycles =
                            (op_mid == REG_HL_MEM || op_lo == REG_HL_MEM) ? 3'd2 : 3'd1;
                    end
                    2'd2: begin
                        result.recognized = 1'b1; result.inst_length = 2'd1;
                        result.mnemonic = alu_mnemonic(op_mid);
                        result.dst_reg = REG_A; result.src_reg = op_lo;
                        result.machine_cycles = (op_lo == REG_HL_MEM) ? 3'd2 : 3'd1;
                    end
                    2'd0: begin
                        case (op_lo)
                            3'd0: begin
                                // jr cc; the unconditional forms are handled above
                                if (opcode_byte[5]) begin
                                    result = '{1'b1, 2'd2, 3'd3, MN_JR, 3'd0, 3'd0, 2'd0,
                                               1'b1, op_mid[1:0], 3'd0, target};
                                end
                            end
                            3'd1: begin
                                result.recognized = 1'b1;
                                result.pair_sel = op_mid[2:1];
                                if (!opcode_byte[3]) begin
                                    result.mnemonic = MN_LD; result.inst_length = 2'd3;
                                    result.machine_cycles = 3'd3;
                                    result.operand_value = imm16;
                                end else begin
                                    result.mnemonic = MN_ADD; result.inst_length = 2'd1;
                                    result.machine_cycles = 3'd2;
                                end
                            end
                            3'd3: begin
                                result.recognized = 1'b1; result.inst_length = 2'd1;
                                result.machine_cycles = 3'd2;
                                result.pair_sel = op_mid[2:1];
                                result.mnemonic = op_mid[0] ? MN_DEC : MN_INC;
                            end
                            3'd4, 3'd5: begin
                                result.recognized = 1'b1; result.inst_length = 2'd1;
                                result.dst_reg = op_mid;
                                result.mnemonic = op_lo[0] ? MN_DEC : MN_INC;
                                result.machine_cycles = (op_mid == REG_HL_MEM) ? 3'd3 : 3'd1;
                            end
                            3'd6: begin
                                result.recognized = 1'b1; result.inst_length = 2'd2;
                                result.mnemonic = MN_LD;
                                result.dst_reg = op_mid;
                                result.operand_value = {8'd0, next_byte};
                                result.machine_cycles = (op_mid == REG_HL_MEM) ? 3'd3 : 3'd2;
                            end
                            default: begin
                                result = '0;
                            end
                        endcase
                    end
                    default: begin
                        case (op_lo)
                            3'd0: begin
                                if (!opcode_byte[5]) begin
                                    result = '{1'b1, 2'd1, 3'd5, MN_RET, 3'd0, 3'd0, 2'd0,
                                               1'b1, op_mid[1:0], 3'd0, 16'd0};
                                end
                            end
                            3'd1: begin
                                if (!opcode_byte[3]) begin
                                    result = '{1'b1, 2'd1, 3'd3, MN_POP, 3'd0, 3'd0,
                                               op_mid[2:1], 1'b0, 2'd0, 3'd0, 16'd0};
                                end
                            end
                            3'd2: begin
                                if (!opcode_byte[5]) begin
                                    result = '{1'b1, 2'd3, 3'd4, MN_JP, 3'd0, 3'd0, 2'd0,
                                               1'b1, op_mid[1:0], 3'd0, imm16};
                                end
                            end
                            3'd4: begin
                                // e4, ec, f4, fc stay unrecognised
                                if (!opcode_byte[5]) begin
                                    result = '{1'b1, 2'd3, 3'd6, MN_CALL, 3'd0, 3'd0, 2'd0,
                                               1'b1, op_mid[1:0], 3'd0, imm16};
                                end
                            end
                            3'd5: begin
                                if (!opcode_byte[3]) begin
                                    result = '{1'b1, 2'd1, 3'd4, MN_PUSH, 3'd0, 3'd0,
                                               op_mid[2:1], 1'b0, 2'd0, 3'd0, 16'd0};
                                end
                            end
                            3'd6: begin
                                result = '{1'b1, 2'd2, 3'd2, alu_mnemonic(op_mid), REG_A,
                                           3'd0, 2'd0, 1'b0, 2'd0, 3'd0,
                                           {8'd0, next_byte}};
                            end
                            3'd7: begin
                                result = '{1'b1, 2'd1, 3'd4, MN_RST, 3'd0, 3'd0, 2'd0,
                                           1'b0, 2'd0, 3'd0, {10'd0, op_mid, 3'd0}};
                            end
                            default: begin
                                result = '0;
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

endmodule

>>> sv/sm83_instruction_predecoder_core.sv
// Top level of the SM83 instruction predecoder: input register, decode, result register.
// Depends on sm83pd_pkg and sm83pd_decode.
//
// Usage
//   Input channel (s_*): one word per instruction window, carrying the address of
//   the opcode byte and the three bytes found there. Bytes past the instruction's
//   length are ignored.
//   Result channel (m_*): one word per input word, in order, giving the decoded
//   fields. Unknown opcodes come back with m_recognized low and all other fields 0.
//
// Flow and throughput
//   A word taken from the input channel is registered, decoded in the following
//   cycle and, once the result register has room, held there, which raises
//   m_valid. One word is accepted every cycle while m_ready stays high; the rate
//   is set by the two register stages, each of which refills in the cycle it
//   drains.
//
// Reset and stalls
//   aresetn (synchronous, active low) empties both stages; payload registers keep
//   whatever they held. When the receiver holds m_ready low, the result register
//   holds its word and the input stage still fills; s_ready then drops only once
//   both stages are occupied, so no word is lost or repeated.
module sm83_instruction_predecoder_core
    import sm83pd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction_address,
    input  logic [7:0]  s_opcode_byte,
    input  logic [7:0]  s_next_byte,
    input  logic [7:0]  s_third_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_recognized,
    output logic [1:0]  m_inst_length,
    output logic [2:0]  m_machine_cycles,
    output logic [5:0]  m_mnemonic,
    output logic [2:0]  m_dst_reg,
    output logic [2:0]  m_src_reg,
    output logic [1:0]  m_pair_sel,
    output logic        m_has_condition,
    output logic [1:0]  m_condition,
    output logic [2:0]  m_bit_number,
    output logic [15:0] m_operand_value
);

    // Input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] addr_reg;
    logic [7:0]  opcode_reg;
    logic [7:0]  next_byte_reg;
    logic [7:0]  third_byte_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t result_reg;
    dec_result_t decoded;

    logic        in_load;
    logic        out_load;
    logic        out_free;

    // The result register can take a new word when empty or being drained now.
    assign out_free = !out_valid_reg || m_ready;
    // Advance the input stage into the result register whenever it holds a word
    // and there is room.
    assign out_load = in_valid_reg && out_free;
    // The input register frees up in the same cycle it hands its word on.
    assign s_ready  = !in_valid_reg || out_free;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the window; hold it while the result stage is stalled.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            addr_reg       <= s_instruction_address;
            opcode_reg     <= s_opcode_byte;
            next_byte_reg  <= s_next_byte;
            third_byte_reg <= s_third_byte;
        end
    end

    sm83pd_decode u_decode (
        .instruction_address (addr_reg),
        .opcode_byte         (opcode_reg),
        .next_byte           (next_byte_reg),
        .third_byte          (third_byte_reg),
        .result              (decoded)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg <= decoded;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_recognized     = result_reg.recognized;
    assign m_inst_length    = result_reg.inst_length;
    assign m_machine_cycles = result_reg.machine_cycles;
    assign m_mnemonic       = result_reg.mnemonic;
    assign m_dst_reg        = result_reg.dst_reg;
    assign m_src_reg        = result_reg.src_reg;
    assign m_pair_sel       = result_reg.pair_sel;
    assign m_has_condition  = result_reg.has_condition;
    assign m_condition      = result_reg.condition;
    assign m_bit_number     = result_reg.bit_number;
    assign m_operand_value  = result_reg.operand_value;

endmodule
